>>> rtl/core/word_count_top_k_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// Word count top-K tracker: assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WORD_COUNT_TOP_K_TRACKER_CORE_DEFINES_SVH
`define WORD_COUNT_TOP_K_TRACKER_CORE_DEFINES_SVH

// Checks a property at every clock edge outside reset.
`define WCTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next cycle.
`define WCTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wctk_pkg.sv
// ----------------------------------------------------------------------------
// Word count top-K tracker package
// Field widths, result status codes and the scan token type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wctk_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned KeyBits   = 10;
  localparam int unsigned CountBits = 20;
  localparam int unsigned SlotBits  = 4;

  // Slot index width that covers the largest supported list (64 entries).
  localparam int unsigned SlotMaxW  = 6;

  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [SlotMaxW-1:0]  slot_t;

  localparam count_t CountMax = '1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_APPENDED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_NOT_KEPT = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  // Request kinds.
  localparam logic KindAdd  = 1'b0;
  localparam logic KindRead = 1'b1;

  // Token that walks down the cell chain during an add.
  typedef struct packed {
    logic   valid;
    logic   found;
    slot_t  found_slot;
    count_t min_cnt;
    slot_t  min_slot;
  } scan_tok_t;

endpackage

>>> rtl/core/wctk_if.sv
// ----------------------------------------------------------------------------
// Word count top-K tracker channel interfaces
// Valid/ready request channel and result channel with their payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Request channel: one word occurrence or a list readout.
interface wctk_in_if import wctk_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  key_t word_id;

  modport source (output valid, output kind, output word_id, input ready);
  modport sink   (input valid, input kind, input word_id, output ready);
endinterface

// Result channel.
interface wctk_out_if import wctk_pkg::*; ();
  logic                valid;
  logic                ready;
  key_t                key_out;
  count_t              count_out;
  logic [SlotBits-1:0] slot_out;
  status_e             status;
  logic                last;

  modport source (output valid, output key_out, output count_out, output slot_out,
                  output status, output last, input ready);
  modport sink   (input valid, input key_out, input count_out, input slot_out,
                  input status, input last, output ready);
endinterface

>>> rtl/core/word_count_top_k_tracker_core.sv
// Add (word in range): the result is registered once the token has passed every cell of the chain.
// Adds do not overlap in the cell chain; an out-of-range word gives a single result.
// Read: fill count results, one per cycle unless the output stalls; empty list: a single result.
// One request is in flight at a time; a request is taken only when the output register is empty.
// After reset the counter RAM is cleared word by word, during which ready stays low.
// ----------------------------------------------------------------------------
// Word count top-K tracker core
// Counts word occurrences in a RAM and keeps a top list in a chain of cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_count_top_k_tracker_core import wctk_pkg::*; #(
  parameter int unsigned NUM_WORDS   = 1024,
  parameter int unsigned TOP_ENTRIES = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wctk_in_if.sink     in_i,
  wctk_out_if.source  out_o
);

`include "word_count_top_k_tracker_core_defines.svh"

  localparam int unsigned AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned SlotW = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(TOP_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RMW   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DUMP  = 6'b010000,
    S_SPARE = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [AW-1:0]       addr_q, addr_d;
  key_t                word_q, word_d;
  count_t              cnt_q, cnt_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [SlotW-1:0]    rd_idx_q, rd_idx_d;

  // Output register.
  logic                out_vld_q;
  key_t                out_key_q;
  count_t              out_cnt_q;
  logic [SlotBits-1:0] out_slot_q;
  status_e             out_st_q;
  logic                out_last_q;

  logic                ld;
  key_t                ld_key;
  count_t              ld_cnt;
  slot_t               ld_slot;
  status_e             ld_st;
  logic                ld_last;

  // Counter RAM ports.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  count_t              ram_wdata;
  logic                ram_re;
  count_t              ram_rdata;
  count_t              cnt_inc;

  // Cell chain.
  scan_tok_t           tok_c [TOP_ENTRIES+1];
  scan_tok_t           tok_end;
  logic [TOP_ENTRIES-1:0] cell_vld;
  logic [TOP_ENTRIES-1:0] cell_wr;
  key_t                cell_key [TOP_ENTRIES];
  count_t              cell_cnt [TOP_ENTRIES];

  // List decision at the end of a scan.
  logic                dec_we;
  slot_t               dec_slot;
  status_e             dec_st;

  logic                in_acc;
  logic                out_free;
  logic                in_range;
  logic                rd_last;
  logic                append_now;
  logic [FillW-1:0]    fill_inc;

  assign in_i.ready = (state_q == S_IDLE) && !out_vld_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign in_range   = (32'(in_i.word_id) < 32'(NUM_WORDS));
  assign cnt_inc    = (ram_rdata == CountMax) ? ram_rdata : ram_rdata + count_t'(1);
  assign tok_end    = tok_c[TOP_ENTRIES];
  assign rd_last    = ((FillW'(rd_idx_q) + FillW'(1)) == fill_q);
  assign append_now = dec_we && (dec_st == ST_APPENDED);
  assign fill_inc   = fill_q + FillW'(1);

  // Counter RAM, cleared after reset.
  wctk_ram #(
    .WIDTH (CountBits),
    .DEPTH (NUM_WORDS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AW'(in_i.word_id)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_re    = in_acc && (in_i.kind == KindAdd) && in_range;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = cnt_inc;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_RMW) begin
      ram_we    = 1'b1;
    end
  end

  // Launch token enters the first cell in the read-modify-write cycle.
  always_comb begin
    tok_c[0]            = '0;
    tok_c[0].valid      = (state_q == S_RMW);
  end

  // Chain of list cells.
  for (genvar g = 0; g < TOP_ENTRIES; g++) begin : g_cell
    assign cell_vld[g] = (fill_q > FillW'(g));
    assign cell_wr[g]  = dec_we && (dec_slot == SlotMaxW'(g));

    wctk_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_c[g]),
      .tok_o    (tok_c[g+1]),
      .vld_i    (cell_vld[g]),
      .word_i   (word_q),
      .wr_i     (cell_wr[g]),
      .wr_key_i (word_q),
      .wr_cnt_i (cnt_q),
      .key_o    (cell_key[g]),
      .cnt_o    (cell_cnt[g])
    );
  end

  // Decide where the word goes once the token has passed every cell.
  always_comb begin
    dec_we   = 1'b0;
    dec_slot = '0;
    dec_st   = ST_NOT_KEPT;
    if (tok_end.valid) begin
      if (tok_end.found) begin
        dec_we   = 1'b1;
        dec_slot = tok_end.found_slot;
        dec_st   = ST_UPDATED;
      end else if (fill_q < FillW'(TOP_ENTRIES)) begin
        dec_we   = 1'b1;
        dec_slot = SlotMaxW'(fill_q);
        dec_st   = ST_APPENDED;
      end else if (tok_end.min_cnt < cnt_q) begin
        dec_we   = 1'b1;
        dec_slot = tok_end.min_slot;
        dec_st   = ST_REPLACED;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    addr_d   = addr_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    rd_idx_d = rd_idx_q;
    ld       = 1'b0;
    ld_key   = '0;
    ld_cnt   = '0;
    ld_slot  = '0;
    ld_st    = ST_EMPTY;
    ld_last  = 1'b1;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NUM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.kind == KindRead) begin
            if (fill_q == '0) begin
              ld = 1'b1;
            end else begin
              rd_idx_d = '0;
              state_d  = S_DUMP;
            end
          end else if (!in_range) begin
            ld     = 1'b1;
            ld_key = in_i.word_id;
            ld_st  = ST_NOT_KEPT;
          end else begin
            addr_d  = AW'(in_i.word_id);
            word_d  = in_i.word_id;
            state_d = S_RMW;
          end
        end
      end
      S_RMW: begin
        cnt_d   = cnt_inc;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (tok_end.valid) begin
          ld      = 1'b1;
          ld_key  = word_q;
          ld_cnt  = cnt_q;
          ld_slot = dec_slot;
          ld_st   = dec_st;
          if (dec_st == ST_APPENDED) begin
            fill_d = fill_q + FillW'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_key  = cell_key[rd_idx_q];
          ld_cnt  = cell_cnt[rd_idx_q];
          ld_slot = SlotMaxW'(rd_idx_q);
          ld_st   = ST_ENTRY;
          ld_last = rd_last;
          if (rd_last) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + SlotW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      fill_q    <= fill_d;
      rd_idx_q  <= rd_idx_d;
      if (ld) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    word_q <= word_d;
    cnt_q  <= cnt_d;
    if (ld) begin
      out_key_q  <= ld_key;
      out_cnt_q  <= ld_cnt;
      out_slot_q <= ld_slot[SlotBits-1:0];
      out_st_q   <= ld_st;
      out_last_q <= ld_last;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.key_out   = out_key_q;
  assign out_o.count_out = out_cnt_q;
  assign out_o.slot_out  = out_slot_q;
  assign out_o.status    = out_st_q;
  assign out_o.last      = out_last_q;

  // The fill count never passes the list size.
  `WCTK_ASSERT(a_fill_bound, fill_q <= FillW'(TOP_ENTRIES), "top list fill overflow")

  // A token only reaches the chain end while a scan is pending.
  `WCTK_ASSERT(a_tok_in_scan, !tok_end.valid || (state_q == S_SCAN), "stray scan token")

  // An append grows the list by exactly one entry.
  `WCTK_ASSERT_NEXT(a_append_fill, append_now, fill_q == $past(fill_inc), "list did not grow")

endmodule

>>> rtl/core/wctk_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wctk_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/wctk_cell.sv
// ----------------------------------------------------------------------------
// Top list cell
// Holds one list slot and refines the scan token on its way down the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wctk_cell import wctk_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_tok_t tok_i,
  output scan_tok_t tok_o,
  input  logic      vld_i,
  input  key_t      word_i,
  input  logic      wr_i,
  input  key_t      wr_key_i,
  input  count_t    wr_cnt_i,
  output key_t      key_o,
  output count_t    cnt_o
);

  localparam slot_t MySlot = SlotMaxW'(CELL_IDX);

  key_t      key_q;
  count_t    cnt_q;
  scan_tok_t tok_d;
  scan_tok_t tok_q;
  logic      tok_vld_q;

  // Match against the word being added and track the first lowest count.
  always_comb begin
    tok_d = tok_i;
    if (vld_i && !tok_i.found && (key_q == word_i)) begin
      tok_d.found      = 1'b1;
      tok_d.found_slot = MySlot;
    end
    if ((CELL_IDX == 0) || (cnt_q < tok_i.min_cnt)) begin
      tok_d.min_cnt  = cnt_q;
      tok_d.min_slot = MySlot;
    end
  end

  // Token valid travels with reset; the rest is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  // Slot contents, written when the decision lands on this slot.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q <= wr_key_i;
      cnt_q <= wr_cnt_i;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_vld_q;
  end

  assign key_o = key_q;
  assign cnt_o = cnt_q;

endmodule
